// ----- rtl/eadsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadsr_pkg
// Shared types and constants of the exponential ADSR envelope unit.
// ----------------------------------------------------------------------------
package eadsr_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int OUT_LVL_W  = 24;
	localparam int MUL_W      = 32;
	localparam int LOG_FRAC   = 24;
	localparam int DVW        = 36;

	localparam logic [MUL_W-1:0] MULT_ONE = 32'h4000_0000;
	localparam logic [MUL_W-1:0] LN2_Q30  = 32'd744261118;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LVL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MINIMUM_LVL = 3'd4;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_ENTER = 1'b1;

	typedef enum logic [2:0] {
		STG_OFF     = 3'd0,
		STG_ATTACK  = 3'd1,
		STG_DECAY   = 3'd2,
		STG_SUSTAIN = 3'd3,
		STG_RELEASE = 3'd4
	} stage_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_ENTER,
		CS_LOGE_GO,
		CS_LOGE_WAIT,
		CS_LOGS_GO,
		CS_LOGS_WAIT,
		CS_SCALE_GO,
		CS_SCALE_WAIT,
		CS_DIV_GO,
		CS_DIV_WAIT,
		CS_STEP_GO,
		CS_STEP_WAIT,
		CS_RESULT
	} ctl_state_t;

	typedef enum logic [1:0] {
		LG_IDLE,
		LG_NORM,
		LG_SQ_GO,
		LG_SQ_WAIT
	} log_state_t;

	// handshake of a multi-cycle arithmetic unit
	typedef struct packed {
		logic start;
	} unit_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;

endpackage

// ----- rtl/eadsr_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadsr_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module eadsr_mul (
	input  logic clk,
	input  logic arst_n,
	input  eadsr_pkg::unit_req_t req,
	input  logic [eadsr_pkg::MUL_W-1:0] a,
	input  logic [eadsr_pkg::MUL_W-1:0] b,
	output eadsr_pkg::unit_rsp_t rsp,
	output logic [2*eadsr_pkg::MUL_W-1:0] prod
);
	import eadsr_pkg::*;

	localparam int CNT_W = $clog2(MUL_W);

	logic [MUL_W-1:0]   a_q;
	logic [MUL_W-1:0]   b_q;
	logic [2*MUL_W-1:0] acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_W:0]     sum;

	assign sum = {1'b0, acc_q[2*MUL_W-1:MUL_W]} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[MUL_W-1:1]};
			b_q   <= {1'b0, b_q[MUL_W-1:1]};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign prod     = acc_q;

endmodule

// ----- rtl/eadsr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadsr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eadsr_div #(
	parameter int LB = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  eadsr_pkg::unit_req_t req,
	input  logic [eadsr_pkg::DVW-1:0] dividend,
	input  logic [LB-1:0] divisor,
	output eadsr_pkg::unit_rsp_t rsp,
	output logic [eadsr_pkg::DVW-1:0] quotient
);
	import eadsr_pkg::*;

	localparam int CNT_W = $clog2(DVW);

	logic [LB-1:0]    rem_q;
	logic [LB-1:0]    dvs_q;
	logic [DVW-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LB:0]      trial;
	logic [LB:0]      diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits leave at the top as quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LB-1:0] : trial[LB-1:0];
			quo_q <= {quo_q[DVW-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/eadsr_log.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadsr_log
// log2 of a level in Q.24: serial normalise, then 24 squarings of the mantissa.
// ----------------------------------------------------------------------------
module eadsr_log #(
	parameter int LFB = 23
) (
	input  logic clk,
	input  logic arst_n,
	input  eadsr_pkg::unit_req_t req,
	input  logic [30:0] x,
	output eadsr_pkg::unit_rsp_t rsp,
	output logic signed [31:0] result
);
	import eadsr_pkg::*;

	log_state_t state_q, state_d;

	logic [30:0]          m_q;
	logic [4:0]           p_q;
	logic [4:0]           iter_q;
	logic [LOG_FRAC-1:0]  frac_q;
	logic                 done_q;
	unit_req_t            mreq;
	unit_rsp_t            mrsp;
	logic [2*MUL_W-1:0]   mprod;
	logic [31:0]          m2;
	logic [7:0]           int_part;

	eadsr_mul u_sq (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.a     (MUL_W'(m_q)),
		.b     (MUL_W'(m_q)),
		.rsp   (mrsp),
		.prod  (mprod)
	);

	assign m2 = mprod[61:30];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LG_IDLE:    if (req.start) state_d = LG_NORM;
			LG_NORM:    if (m_q[30] || p_q == '0) state_d = LG_SQ_GO;
			LG_SQ_GO:   state_d = LG_SQ_WAIT;
			LG_SQ_WAIT: begin
				if (mrsp.done) state_d = (iter_q == 5'(LOG_FRAC - 1)) ? LG_IDLE : LG_SQ_GO;
			end
			default:    state_d = LG_IDLE;
		endcase
	end

	always_comb begin
		mreq.start = (state_q == LG_SQ_GO);
		rsp.busy   = (state_q != LG_IDLE);
		rsp.done   = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == LG_SQ_WAIT) && mrsp.done && (iter_q == 5'(LOG_FRAC - 1));
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			LG_IDLE: begin
				if (req.start) begin
					m_q    <= x;
					p_q    <= 5'd30;
					iter_q <= '0;
					frac_q <= '0;
				end
			end
			LG_NORM: begin
				if (!m_q[30] && p_q != '0) begin
					m_q <= {m_q[29:0], 1'b0};
					p_q <= p_q - 1'b1;
				end
			end
			LG_SQ_WAIT: begin
				if (mrsp.done) begin
					m_q    <= m2[31] ? m2[31:1] : m2[30:0];
					frac_q <= {frac_q[LOG_FRAC-2:0], m2[31]};
					iter_q <= iter_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign int_part = 8'(p_q) - 8'(LFB);
	assign result   = $signed({int_part, frac_q});

endmodule

// ----- rtl/exponential_adsr_envelope_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exponential_adsr_envelope_unit
// Exponential ADSR envelope with serial multiplier, logarithm and divider.
// ----------------------------------------------------------------------------
// One item is handled at a time. A sample tick in a timed stage runs the
// bit-serial multiply of level by step factor; ticks in off or sustain,
// unknown stage codes and entry commands to off or sustain skip it. Entering
// attack, decay or release (by command or when a stage ends) runs two
// logarithms, each a serial normalise plus 24 squarings, then a scaling
// multiply and a division; an entry that came from a tick is then followed
// by the tick multiply. A zero length or zero level skips the logarithm,
// scaling and division work. The result sits in an output register until
// its transfer completes.
// ----------------------------------------------------------------------------
module exponential_adsr_envelope_unit #(
	parameter int LENGTH_BITS     = 24,
	parameter int LEVEL_FRAC_BITS = 23
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic [eadsr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [eadsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic opcode,
	input  logic [2:0] target_stage,
	output logic out_valid,
	input  logic out_ready,
	output logic [eadsr_pkg::OUT_LVL_W-1:0] level,
	output logic [2:0] stage
);
	import eadsr_pkg::*;

	localparam int LB = LENGTH_BITS;
	localparam int LW = LEVEL_FRAC_BITS + 1;
	localparam int CW = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;
	localparam logic [LW-1:0] ONE_L = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	ctl_state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] attack_q, decay_q, release_q, sustain_q, minimum_q;

	stage_t          stage_q;
	stage_t          es_q;
	logic            tick_q;
	logic [LB-1:0]   count_q;
	logic [LB-1:0]   end_q;
	logic [LW-1:0]   level_q;
	logic [MUL_W-1:0] mult_q;
	logic [LW-1:0]   lstart_q, lend_q;
	logic signed [31:0] loge_q;
	logic [MUL_W-1:0] mag_q;
	logic            neg_q;
	logic            out_valid_q;
	logic [OUT_LVL_W-1:0] level_out_q;
	logic [2:0]      stage_out_q;

	logic            accept;
	logic            timed;
	stage_t          next_stg;
	logic [LW-1:0]   mn, su;
	logic [LB-1:0]   ent_len;
	logic [LW-1:0]   ent_level, ent_lstart, ent_lend;
	logic            need_log;
	logic signed [31:0] d;
	logic            out_free;

	unit_req_t       mreq, lreq, dreq;
	unit_rsp_t       mrsp, lrsp, drsp;
	logic [MUL_W-1:0] ma, mb;
	logic [2*MUL_W-1:0] mprod;
	logic [30:0]     lx;
	logic signed [31:0] lres;
	logic [DVW-1:0]  quo;
	logic [MUL_W:0]  psum;
	logic [MUL_W-1:0] mult_new;
	logic [33:0]     lv;

	function automatic logic [LW-1:0] clamp_cfg(input logic [CFG_DATA_W-1:0] v);
		logic [LW-1:0] r;
		r = (CW'(v) > CW'(ONE_L)) ? ONE_L : LW'(v);
		return r;
	endfunction

	eadsr_mul u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq), .a(ma), .b(mb), .rsp(mrsp), .prod(mprod)
	);

	eadsr_log #(.LFB(LEVEL_FRAC_BITS)) u_log (
		.clk(clk), .arst_n(arst_n), .req(lreq), .x(lx), .rsp(lrsp), .result(lres)
	);

	eadsr_div #(.LB(LB)) u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq),
		.dividend(mprod[LOG_FRAC+DVW-1:LOG_FRAC]), .divisor(end_q),
		.rsp(drsp), .quotient(quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= 24'd480;
			decay_q   <= 24'd24000;
			release_q <= 24'd48000;
			sustain_q <= 24'd838861;
			minimum_q <= 24'd839;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_ATTACK_LEN:  attack_q  <= cfg_wdata;
				REG_DECAY_LEN:   decay_q   <= cfg_wdata;
				REG_RELEASE_LEN: release_q <= cfg_wdata;
				REG_SUSTAIN_LVL: sustain_q <= cfg_wdata;
				REG_MINIMUM_LVL: minimum_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign accept   = in_valid && in_ready;
	assign timed    = (stage_q == STG_ATTACK) || (stage_q == STG_DECAY) ||
	                  (stage_q == STG_RELEASE);
	assign out_free = !out_valid_q || out_ready;
	assign mn       = clamp_cfg(minimum_q);
	assign su       = clamp_cfg(sustain_q);

	always_comb begin
		unique case (stage_q)
			STG_ATTACK:  next_stg = STG_DECAY;
			STG_DECAY:   next_stg = STG_SUSTAIN;
			STG_RELEASE: next_stg = STG_OFF;
			default:     next_stg = STG_OFF;
		endcase
	end

	// values set on stage entry
	always_comb begin
		ent_len    = '0;
		ent_level  = level_q;
		ent_lstart = '0;
		ent_lend   = '0;
		unique case (es_q)
			STG_ATTACK: begin
				ent_len    = LB'(attack_q);
				ent_level  = mn;
				ent_lstart = mn;
				ent_lend   = ONE_L;
			end
			STG_DECAY: begin
				ent_len    = LB'(decay_q);
				ent_level  = ONE_L;
				ent_lstart = ONE_L;
				ent_lend   = (su > mn) ? su : mn;
			end
			STG_SUSTAIN: ent_level = su;
			STG_RELEASE: begin
				ent_len    = LB'(release_q);
				ent_lstart = level_q;
				ent_lend   = mn;
			end
			default: ent_level = '0;
		endcase
	end

	assign need_log = (ent_len != '0) && (ent_lstart != '0) && (ent_lend != '0);
	assign d        = loge_q - lres;

	// saturate 1.0 +/- quotient into the unsigned Q2.30 range
	assign psum = (MUL_W+1)'(MULT_ONE) + (MUL_W+1)'(quo);
	always_comb begin
		if (neg_q) begin
			mult_new = (quo > DVW'(MULT_ONE)) ? '0 : MUL_W'(DVW'(MULT_ONE) - quo);
		end else begin
			mult_new = ((DVW+1)'(psum) > (DVW+1)'({MUL_W{1'b1}})) || (DVW > MUL_W &&
			           quo[DVW-1:MUL_W] != '0) ? {MUL_W{1'b1}} : psum[MUL_W-1:0];
		end
	end

	assign lv = mprod[63:30];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (accept) begin
					if (opcode == OP_ENTER) begin
						state_d = (target_stage <= 3'(STG_RELEASE)) ? CS_ENTER : CS_RESULT;
					end else if (timed) begin
						state_d = (count_q == end_q) ? CS_ENTER : CS_STEP_GO;
					end else begin
						state_d = CS_RESULT;
					end
				end
			end
			CS_ENTER: begin
				if (need_log)    state_d = CS_LOGE_GO;
				else if (tick_q) state_d = CS_STEP_GO;
				else             state_d = CS_RESULT;
			end
			CS_LOGE_GO:    state_d = CS_LOGE_WAIT;
			CS_LOGE_WAIT:  if (lrsp.done) state_d = CS_LOGS_GO;
			CS_LOGS_GO:    state_d = CS_LOGS_WAIT;
			CS_LOGS_WAIT:  if (lrsp.done) state_d = CS_SCALE_GO;
			CS_SCALE_GO:   state_d = CS_SCALE_WAIT;
			CS_SCALE_WAIT: if (mrsp.done) state_d = CS_DIV_GO;
			CS_DIV_GO:     state_d = CS_DIV_WAIT;
			CS_DIV_WAIT: begin
				if (drsp.done) state_d = tick_q ? CS_STEP_GO : CS_RESULT;
			end
			CS_STEP_GO:    state_d = CS_STEP_WAIT;
			CS_STEP_WAIT:  if (mrsp.done) state_d = CS_RESULT;
			CS_RESULT:     if (out_free) state_d = CS_IDLE;
			default:       state_d = CS_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = (state_q == CS_IDLE);
		lreq.start = (state_q == CS_LOGE_GO) || (state_q == CS_LOGS_GO);
		lx         = 31'((state_q == CS_LOGE_GO) ? lend_q : lstart_q);
		mreq.start = (state_q == CS_SCALE_GO) || (state_q == CS_STEP_GO);
		dreq.start = (state_q == CS_DIV_GO);
		if (state_q == CS_SCALE_GO) begin
			ma = mag_q;
			mb = LN2_Q30;
		end else begin
			ma = MUL_W'(level_q);
			mb = mult_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			stage_q     <= STG_OFF;
			count_q     <= '0;
			end_q       <= '0;
			level_q     <= '0;
			mult_q      <= MULT_ONE;
			out_valid_q <= 1'b0;
			es_q        <= STG_OFF;
			tick_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == CS_RESULT && out_free) out_valid_q <= 1'b1;
			else if (out_ready)                   out_valid_q <= 1'b0;
			unique case (state_q)
				CS_IDLE: begin
					if (accept) begin
						tick_q <= (opcode == OP_TICK);
						es_q   <= (opcode == OP_ENTER) ? stage_t'(target_stage) : next_stg;
					end
				end
				CS_ENTER: begin
					stage_q <= es_q;
					count_q <= '0;
					end_q   <= ent_len;
					level_q <= ent_level;
					mult_q  <= MULT_ONE;
				end
				CS_DIV_WAIT: if (drsp.done) mult_q <= mult_new;
				CS_STEP_WAIT: begin
					if (mrsp.done) begin
						level_q <= (lv > 34'(ONE_L)) ? ONE_L : LW'(lv);
						count_q <= count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// operand and result payload
	always_ff @(posedge clk) begin
		if (state_q == CS_ENTER) begin
			lstart_q <= ent_lstart;
			lend_q   <= ent_lend;
		end
		if (state_q == CS_LOGE_WAIT && lrsp.done) loge_q <= lres;
		if (state_q == CS_LOGS_WAIT && lrsp.done) begin
			neg_q <= d < 0;
			mag_q <= (d < 0) ? MUL_W'(-d) : MUL_W'(d);
		end
		if (state_q == CS_RESULT && out_free) begin
			level_out_q <= OUT_LVL_W'(CW'(level_q));
			stage_out_q <= stage_q;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_out_q;
	assign stage     = stage_out_q;

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= ONE_L) else $error("envelope level above one");
	a_off_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == STG_OFF) |-> (level_q == '0)) else $error("level not zero in off");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("second item taken while busy");
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == CS_RESULT))
		else $error("result raised outside result state");
`endif

endmodule
